// ===== design/mtdm_pkg.sv =====
// ----------------------------------------------------------------------------
// mtdm_pkg
// Types, constants and helpers for the stereo multi-tap delay unit.
// ----------------------------------------------------------------------------
package mtdm_pkg;

    localparam int HIST_DEPTH = 131072;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int MAX_TAPS   = 16;
    localparam int TAP_IW     = $clog2(MAX_TAPS);
    localparam int CFG_IW     = 3;
    localparam int CFG_DW     = 17;

    localparam logic [CFG_IW-1:0] REG_TAP_COUNT = 3'd0;
    localparam logic [CFG_IW-1:0] REG_GAIN      = 3'd1;
    localparam logic [CFG_IW-1:0] REG_FB_COEF   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_FB_DELAY  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_WET       = 3'd4;
    localparam logic [CFG_IW-1:0] REG_DRY       = 3'd5;

    localparam logic [15:0] ONE_Q15 = 16'h8000;

    typedef enum logic {
        FUNC_FRAME = 1'b0,
        FUNC_LOAD  = 1'b1
    } t_func;

    typedef struct packed {
        t_func              func;
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
        logic [3:0]         tap_slot;
        logic [16:0]        tap_delay;
        logic signed [15:0] tap_weight;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAP,
        S_BL1,
        S_BL2,
        S_GAIN,
        S_MIX1,
        S_MIX2
    } t_state;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [42:0] v);
        logic signed [39:0] r;
        if (v > 43'sh07f_ffff_ffff) begin
            r = 40'sh7f_ffff_ffff;
        end else if (v < -43'sh080_0000_0000) begin
            r = 40'sh80_0000_0000;
        end else begin
            r = v[39:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] clamp_q15(input logic [15:0] v);
        return (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

endpackage

// ===== design/mtdm_ram.sv =====
// ----------------------------------------------------------------------------
// mtdm_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mtdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== design/multitap_delay_mix_feedback_unit.sv =====
// ----------------------------------------------------------------------------
// multitap_delay_mix_feedback_unit
// Stereo sparse FIR with output feedback, gain, clip and wet/dry mix.
//
//  port group  direction  handshake              contents
//  in          to block   i_in_valid/o_in_stall  frame samples or tap load
//  out         from block o_out_valid/i_out_stall mixed stereo sample
//  cfg         to block   i_cfg_we               register index and data
//
// a frame holds o_in_stall from when it is taken until its result goes to the
// output register (one input history read per tap for n taps, n being
// tap_count limited to 16, a drain of the read data and product registers,
// then blend, gain and mix), the last step waiting while the previous word
// is stalled at the output; a tap load gives no output
// history entries never written since reset read as zero through a fill mark,
// so there is no clearing pass after reset
// a finished word waits in the output register while the next input is taken
// ----------------------------------------------------------------------------
module multitap_delay_mix_feedback_unit
    import mtdm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_data,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [4:0]  r_tap_count;
    logic [14:0] r_gain;
    logic [15:0] r_fb_coef;
    logic [16:0] r_fb_delay;
    logic [15:0] r_wet;
    logic [15:0] r_dry;

    logic [16:0]        r_tap_pos [MAX_TAPS];
    logic signed [15:0] r_tap_w   [MAX_TAPS];

    logic [HIST_AW-1:0] r_wp;
    logic               r_wrap;
    logic [4:0]         r_idx;
    logic               r_v1, r_v2, r_ok1, r_fb_ok;
    logic signed [15:0] r_w1;

    logic signed [15:0] r_x   [2];
    logic signed [31:0] r_pr  [2];
    logic signed [39:0] r_acc [2];
    logic signed [57:0] r_p1  [2];
    logic signed [57:0] r_p2  [2];
    logic signed [15:0] r_eff [2];
    logic signed [33:0] r_md  [2];
    logic signed [33:0] r_mw  [2];

    logic               r_ov;
    t_out_word          r_out;

    logic               in_acc, issue, out_free, out_load, fb_on;
    logic [4:0]         tap_n;
    logic [15:0]        fb_e, wet_e, dry_e;
    logic [HIST_AW-1:0] tap_addr, fb_addr;
    logic [31:0]        in_rd, out_rd;
    logic signed [17:0] s_om, s_fb;
    logic signed [16:0] s_wet, s_dry;
    logic signed [15:0] s_gain;
    logic signed [57:0] c_bl  [2];
    logic signed [55:0] c_gp  [2];
    logic signed [34:0] c_mx  [2];
    logic signed [39:0] c_acc [2];
    logic signed [15:0] c_eff [2];
    logic signed [15:0] c_res [2];
    logic signed [27:0] c_prev [2];

    assign tap_n  = (r_tap_count > 5'(MAX_TAPS)) ? 5'(MAX_TAPS) : r_tap_count;
    assign fb_e   = clamp_q15(r_fb_coef);
    assign wet_e  = clamp_q15(r_wet);
    assign dry_e  = clamp_q15(r_dry);
    assign fb_on  = (fb_e != 16'd0);
    assign s_om   = 18'(ONE_Q15) - 18'(fb_e);
    assign s_fb   = 18'(fb_e);
    assign s_wet  = 17'(wet_e);
    assign s_dry  = 17'(dry_e);
    assign s_gain = 16'(r_gain);

    assign tap_addr = r_wp - r_tap_pos[r_idx[TAP_IW-1:0]][HIST_AW-1:0];
    assign fb_addr  = r_wp - r_fb_delay[HIST_AW-1:0];

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_ov || !i_out_stall;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // fsm
    always_comb begin
        n_state  = r_state;
        issue    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_data.func == FUNC_FRAME) begin
                    n_state = S_TAP;
                end
            end
            S_TAP: begin
                if (r_idx < tap_n) begin
                    issue = 1'b1;
                end else if (!r_v1 && !r_v2) begin
                    n_state = S_BL1;
                end
            end
            S_BL1:  n_state = S_BL2;
            S_BL2:  n_state = S_GAIN;
            S_GAIN: n_state = S_MIX1;
            S_MIX1: n_state = S_MIX2;
            S_MIX2: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    mtdm_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_in_hist (
        .i_clk   (i_clk),
        .i_we    (in_acc && i_in_data.func == FUNC_FRAME),
        .i_waddr (r_wp),
        .i_wdata ({i_in_data.right_in, i_in_data.left_in}),
        .i_re    (issue),
        .i_raddr (tap_addr),
        .o_rdata (in_rd)
    );

    mtdm_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_out_hist (
        .i_clk   (i_clk),
        .i_we    (out_load),
        .i_waddr (r_wp),
        .i_wdata ({c_res[1], c_res[0]}),
        .i_re    (in_acc),
        .i_raddr (fb_addr),
        .o_rdata (out_rd)
    );

    always_comb begin
        for (int ch = 0; ch < 2; ch++) begin
            c_prev[ch] = r_fb_ok ? {out_rd[16*ch +: 16], 12'd0} : 28'sd0;
            c_bl[ch]   = (r_p1[ch] + r_p2[ch] + 58'sd16384) >>> 15;
            c_acc[ch]  = sat40(c_bl[ch][42:0]);
            c_gp[ch]   = (r_acc[ch] * s_gain + 56'sd8388608) >>> 24;
            c_eff[ch]  = sat16(c_gp[ch][31:0]);
            c_mx[ch]   = (35'(r_md[ch]) + 35'(r_mw[ch]) + 35'sd16384) >>> 15;
            c_res[ch]  = sat16(32'(c_mx[ch]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap_count <= 5'd0;
            r_gain      <= 15'd4096;
            r_fb_coef   <= 16'd0;
            r_fb_delay  <= 17'd1;
            r_wet       <= ONE_Q15;
            r_dry       <= 16'd0;
            r_wp        <= '0;
            r_wrap      <= 1'b0;
            r_idx       <= 5'd0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_ov        <= 1'b0;
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_tap_pos[i] <= 17'd0;
                r_tap_w[i]   <= 16'sd0;
            end
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TAP_COUNT: r_tap_count <= i_cfg_data[4:0];
                    REG_GAIN:      r_gain      <= i_cfg_data[14:0];
                    REG_FB_COEF:   r_fb_coef   <= i_cfg_data[15:0];
                    REG_FB_DELAY:  r_fb_delay  <= i_cfg_data[16:0];
                    REG_WET:       r_wet       <= i_cfg_data[15:0];
                    REG_DRY:       r_dry       <= i_cfg_data[15:0];
                    default:       ;
                endcase
            end
            if (in_acc && i_in_data.func == FUNC_LOAD) begin
                r_tap_pos[i_in_data.tap_slot[TAP_IW-1:0]] <= i_in_data.tap_delay;
                r_tap_w[i_in_data.tap_slot[TAP_IW-1:0]]   <= i_in_data.tap_weight;
            end
            if (in_acc) begin
                r_idx <= 5'd0;
            end else if (issue) begin
                r_idx <= r_idx + 5'd1;
            end
            if (out_load) begin
                r_wp <= r_wp + HIST_AW'(1);
                if (&r_wp) begin
                    r_wrap <= 1'b1;
                end
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x[0]  <= i_in_data.left_in;
            r_x[1]  <= i_in_data.right_in;
            r_fb_ok <= r_wrap || (fb_addr < r_wp);
        end
        r_ok1 <= r_wrap || (tap_addr <= r_wp);
        r_w1  <= r_tap_w[r_idx[TAP_IW-1:0]];
        for (int ch = 0; ch < 2; ch++) begin
            r_pr[ch] <= r_ok1 ? r_w1 * $signed(in_rd[16*ch +: 16]) : 32'sd0;
            if (in_acc) begin
                r_acc[ch] <= 40'sd0;
            end else if (r_v2) begin
                r_acc[ch] <= r_acc[ch] + 40'(r_pr[ch]);
            end else if (r_state == S_BL2 && fb_on) begin
                r_acc[ch] <= c_acc[ch];
            end
            r_p1[ch] <= s_om * r_acc[ch];
            r_p2[ch] <= s_fb * c_prev[ch];
            r_eff[ch] <= c_eff[ch];
            r_md[ch]  <= s_dry * r_x[ch];
            r_mw[ch]  <= s_wet * r_eff[ch];
        end
        if (out_load) begin
            r_out.left_out  <= c_res[0];
            r_out.right_out <= c_res[1];
        end
    end

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.func == FUNC_LOAD |=> r_state == S_IDLE)
        else $error("tap load left idle");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TAP |-> r_idx <= tap_n)
        else $error("tap index past tap count");

    a_wp_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_wp) |-> $past(out_load) || $past(!i_rst_n))
        else $error("write pointer moved without output");

    a_frame_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.func == FUNC_FRAME |=> r_state == S_TAP && r_idx == 5'd0)
        else $error("frame did not start tap pass");

endmodule
